/* design/cco_pkg.sv */
`default_nettype none

package cco_pkg;

	localparam int MAX_OBSTACLES = 16;
	localparam int IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
	localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);

	localparam int CMD_W   = 2;
	localparam int COORD_W = 16;
	localparam int RAD_W   = 11;
	localparam int SHAPE_W = 2;

	localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESOLVE = 2'd2;

	localparam logic [SHAPE_W-1:0] SHAPE_CIRCLE = 2'd0;

	// shared unit widths
	localparam int MUL_W  = COORD_W + 2;
	localparam int PROD_W = 2 * COORD_W + 1;
	localparam int ALU_W  = PROD_W + 1;

	// radius squared, integer; square root result Q.8
	localparam int RR_W       = 2 * RAD_W;
	localparam int SQRT_SHIFT = 16;
	localparam int RADICAND_W = RR_W + SQRT_SHIFT;
	localparam int ROOT_W     = RADICAND_W / 2;
	localparam int REM_W      = ROOT_W + 2;
	localparam int OFF_SHIFT  = 8;
	localparam int NUM_W      = RR_W + OFF_SHIFT + 1;
	localparam int QUO_W      = RAD_W + 1;
	localparam int CYC_W      = 5;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [RAD_W-1:0]          r;
		logic [SHAPE_W-1:0]        shape;
	} obst_t;

	typedef struct packed {
		logic                    sub;
		logic [ALU_W-1:0]        a;
		logic [ALU_W-1:0]        b;
		logic signed [MUL_W-1:0] ma;
		logic signed [MUL_W-1:0] mb;
	} alu_req_t;

	typedef struct packed {
		logic [PROD_W-1:0] prod;
		logic [ALU_W-1:0]  res;
		logic              ge;
	} alu_rsp_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic                      touched;
		logic                      pushed;
	} result_t;

endpackage

`default_nettype wire

/* design/circle_collision_pushout.sv */
// Point versus circle collision resolution over a table of obstacles.
// Input channel (in_valid / in_stall) carries one beat per command:
//   load   - append an obstacle (center, radius, shape); dropped if the table is full
//   clear  - empty the table
//   resolve- walk the table in load order and push the particle out of each circle
// Load and clear give no output beat; command code 3 is ignored.
// Resolve gives one output beat (out_valid / out_stall) with the final position
// and the touched / pushed flags.
// Per stored obstacle, a resolve skips a non-circle, runs the distance test (dx, dy
// and radius squared) for a circle that misses or holds the particle at its center,
// and for a push-out adds a 19-step square root, a multiply by the radius per axis
// and two 12-step divides, all on one shared multiply / add-subtract unit.
// in_stall is high while a resolve is in progress; the next beat is taken the
// cycle after the result moves to the output register.
// While out_stall holds, the output beat stays registered and a new command can
// still be taken; a further result waits inside until the register frees.
// Reset empties the table and clears the output register.

`default_nettype none

module circle_collision_pushout
	import cco_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [CMD_W-1:0]          command,
	input  wire logic signed [COORD_W-1:0] pos_x,
	input  wire logic signed [COORD_W-1:0] pos_y,
	input  wire logic [RAD_W-1:0]          radius,
	input  wire logic [SHAPE_W-1:0]        shape,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic signed [COORD_W-1:0]      new_x,
	output logic signed [COORD_W-1:0]      new_y,
	output logic                           touched,
	output logic                           pushed
);

	logic             in_acc;
	logic             seq_idle;
	logic             res_valid;
	logic             res_take;
	result_t          res;
	result_t          out_q;
	logic             out_valid_q;
	obst_t            wr_data;
	obst_t            rd_data;
	logic [IDX_W-1:0] rd_idx;
	logic [CNT_W-1:0] count;

	assign in_stall = !seq_idle;
	assign in_acc   = in_valid && !in_stall;

	assign wr_data.x     = pos_x;
	assign wr_data.y     = pos_y;
	assign wr_data.r     = radius;
	assign wr_data.shape = shape;

	cco_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (in_acc && (command == CMD_LOAD)),
		.clear   (in_acc && (command == CMD_CLEAR)),
		.wr_data (wr_data),
		.rd_idx  (rd_idx),
		.rd_data (rd_data),
		.count   (count)
	);

	cco_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_acc && (command == CMD_RESOLVE)),
		.start_x   (pos_x),
		.start_y   (pos_y),
		.count     (count),
		.entry     (rd_data),
		.res_take  (res_take),
		.rd_idx    (rd_idx),
		.idle      (seq_idle),
		.res_valid (res_valid),
		.res       (res)
	);

	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
			out_q       <= res;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign new_x     = out_q.x;
	assign new_y     = out_q.y;
	assign touched   = out_q.touched;
	assign pushed    = out_q.pushed;

endmodule

`default_nettype wire

/* design/cco_table.sv */
`default_nettype none

module cco_table
	import cco_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire logic             clear,
	input  wire obst_t            wr_data,
	input  wire logic [IDX_W-1:0] rd_idx,
	output obst_t                 rd_data,
	output logic [CNT_W-1:0]      count
);

	obst_t            mem_q [MAX_OBSTACLES];
	obst_t            rd_q;
	logic [CNT_W-1:0] count_q;
	logic             wr_en;

	assign wr_en = load && (count_q != CNT_W'(MAX_OBSTACLES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clear) begin
			count_q <= '0;
		end else if (wr_en) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[count_q[IDX_W-1:0]] <= wr_data;
		end
		rd_q <= mem_q[rd_idx];
	end

	assign rd_data = rd_q;
	assign count   = count_q;

endmodule

`default_nettype wire

/* design/cco_alu.sv */
`default_nettype none

module cco_alu
	import cco_pkg::*;
(
	input  wire logic     clk,
	input  wire alu_req_t req,
	output alu_rsp_t      rsp
);

	logic signed [2*MUL_W-1:0] prod;
	logic [PROD_W-1:0]         prod_q;
	logic [ALU_W:0]            diff;
	logic [ALU_W-1:0]          sum;

	assign prod = req.ma * req.mb;

	always_ff @(posedge clk) begin
		prod_q <= prod[PROD_W-1:0];
	end

	assign diff = {1'b0, req.a} - {1'b0, req.b};
	assign sum  = req.a + req.b;

	assign rsp.prod = prod_q;
	assign rsp.res  = req.sub ? diff[ALU_W-1:0] : sum;
	assign rsp.ge   = !diff[ALU_W];

endmodule

`default_nettype wire

/* design/cco_seq.sv */
`default_nettype none

module cco_seq
	import cco_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic signed [COORD_W-1:0] start_x,
	input  wire logic signed [COORD_W-1:0] start_y,
	input  wire logic [CNT_W-1:0]          count,
	input  wire obst_t                     entry,
	input  wire logic                      res_take,
	output logic [IDX_W-1:0]               rd_idx,
	output logic                           idle,
	output logic                           res_valid,
	output result_t                        res
);

	typedef enum logic [3:0] {
		S_IDLE, S_READ, S_FETCH, S_MDX, S_MDY, S_MRR, S_CMP, S_SQRT,
		S_MX, S_NUMX, S_DIVX, S_MY, S_NUMY, S_DIVY, S_DONE
	} state_t;

	state_t                    state_q;
	logic [CNT_W-1:0]          idx_q;
	logic signed [COORD_W-1:0] px_q, py_q, cx_q, cy_q;
	logic [RAD_W-1:0]          r_q;
	logic signed [COORD_W:0]   dx_q, dy_q;
	logic [ALU_W-1:0]          d2_q;
	logic [RADICAND_W-1:0]     rad_q;
	logic [REM_W-1:0]          rem_q;
	logic [ROOT_W-1:0]         root_q;
	logic [QUO_W-1:0]          quo_q;
	logic [CYC_W-1:0]          cnt_q;
	logic                      touched_q, pushed_q;

	alu_req_t                  req;
	alu_rsp_t                  rsp;
	logic [COORD_W:0]          magx, magy;
	logic [REM_W+1:0]          sqrt_a;
	logic [ROOT_W:0]           div_a;
	logic [QUO_W-1:0]          quo_nx;

	function automatic logic signed [COORD_W-1:0] sat_add(
		input logic signed [COORD_W-1:0] c,
		input logic [QUO_W-1:0]          q,
		input logic                      neg
	);
		logic signed [COORD_W+1:0] off;
		logic signed [COORD_W+1:0] s;
		off = $signed((COORD_W+2)'(q));
		if (neg) begin
			off = -off;
		end
		s = (COORD_W+2)'(c) + off;
		if (s > (COORD_W+2)'(32767)) begin
			sat_add = 16'sh7FFF;
		end else if (s < -(COORD_W+2)'(32768)) begin
			sat_add = 16'sh8000;
		end else begin
			sat_add = s[COORD_W-1:0];
		end
	endfunction

	cco_alu u_alu (
		.clk (clk),
		.req (req),
		.rsp (rsp)
	);

	assign magx   = dx_q[COORD_W] ? (COORD_W+1)'(-dx_q) : (COORD_W+1)'(dx_q);
	assign magy   = dy_q[COORD_W] ? (COORD_W+1)'(-dy_q) : (COORD_W+1)'(dy_q);
	assign sqrt_a = {rem_q, rad_q[RADICAND_W-1 -: 2]};
	assign div_a  = {rem_q[ROOT_W-1:0], quo_q[QUO_W-1]};
	assign quo_nx = {quo_q[QUO_W-2:0], rsp.ge};

	always_comb begin
		req = '0;
		case (state_q)
			S_MDX: begin
				req.ma = MUL_W'(dx_q);
				req.mb = MUL_W'(dx_q);
			end
			S_MDY: begin
				req.ma = MUL_W'(dy_q);
				req.mb = MUL_W'(dy_q);
			end
			S_MRR: begin
				req.ma = MUL_W'(r_q);
				req.mb = MUL_W'(r_q);
				req.a  = d2_q;
				req.b  = ALU_W'(rsp.prod);
			end
			S_CMP: begin
				req.sub = 1'b1;
				req.a   = ALU_W'(rsp.prod);
				req.b   = d2_q;
			end
			S_SQRT: begin
				req.sub = 1'b1;
				req.a   = ALU_W'(sqrt_a);
				req.b   = ALU_W'({root_q, 2'b01});
			end
			S_MX: begin
				req.ma = MUL_W'(magx);
				req.mb = MUL_W'(r_q);
			end
			S_MY: begin
				req.ma = MUL_W'(magy);
				req.mb = MUL_W'(r_q);
			end
			S_NUMX, S_NUMY: begin
				req.a = ALU_W'({rsp.prod[RR_W-1:0], OFF_SHIFT'(0)});
				req.b = ALU_W'(root_q[ROOT_W-1:1]);
			end
			S_DIVX, S_DIVY: begin
				req.sub = 1'b1;
				req.a   = ALU_W'(div_a);
				req.b   = ALU_W'(root_q);
			end
			default: begin
				req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			idx_q     <= '0;
			px_q      <= '0;
			py_q      <= '0;
			cx_q      <= '0;
			cy_q      <= '0;
			r_q       <= '0;
			dx_q      <= '0;
			dy_q      <= '0;
			d2_q      <= '0;
			rad_q     <= '0;
			rem_q     <= '0;
			root_q    <= '0;
			quo_q     <= '0;
			cnt_q     <= '0;
			touched_q <= 1'b0;
			pushed_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						px_q      <= start_x;
						py_q      <= start_y;
						idx_q     <= '0;
						touched_q <= 1'b0;
						pushed_q  <= 1'b0;
						state_q   <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_FETCH;
				end
				S_FETCH: begin
					if (idx_q == count) begin
						state_q <= S_DONE;
					end else begin
						cx_q <= entry.x;
						cy_q <= entry.y;
						r_q  <= entry.r;
						dx_q <= (COORD_W+1)'(px_q) - (COORD_W+1)'(entry.x);
						dy_q <= (COORD_W+1)'(py_q) - (COORD_W+1)'(entry.y);
						if (entry.shape == SHAPE_CIRCLE) begin
							state_q <= S_MDX;
						end else begin
							idx_q   <= idx_q + CNT_W'(1);
							state_q <= S_READ;
						end
					end
				end
				S_MDX: begin
					state_q <= S_MDY;
				end
				S_MDY: begin
					d2_q    <= ALU_W'(rsp.prod);
					state_q <= S_MRR;
				end
				S_MRR: begin
					d2_q    <= rsp.res;
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (!rsp.ge) begin
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= S_READ;
					end else if (d2_q == '0) begin
						touched_q <= 1'b1;
						idx_q     <= idx_q + CNT_W'(1);
						state_q   <= S_READ;
					end else begin
						touched_q <= 1'b1;
						rad_q     <= {d2_q[RR_W-1:0], SQRT_SHIFT'(0)};
						rem_q     <= '0;
						root_q    <= '0;
						cnt_q     <= CYC_W'(ROOT_W - 1);
						state_q   <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (rsp.ge) begin
						rem_q  <= rsp.res[REM_W-1:0];
						root_q <= {root_q[ROOT_W-2:0], 1'b1};
					end else begin
						rem_q  <= sqrt_a[REM_W-1:0];
						root_q <= {root_q[ROOT_W-2:0], 1'b0};
					end
					rad_q <= rad_q << 2;
					if (cnt_q == '0) begin
						state_q <= S_MX;
					end else begin
						cnt_q <= cnt_q - CYC_W'(1);
					end
				end
				S_MX: begin
					state_q <= S_NUMX;
				end
				S_MY: begin
					state_q <= S_NUMY;
				end
				S_NUMX, S_NUMY: begin
					rem_q   <= REM_W'(rsp.res[NUM_W-1:QUO_W]);
					quo_q   <= rsp.res[QUO_W-1:0];
					cnt_q   <= CYC_W'(QUO_W - 1);
					state_q <= (state_q == S_NUMX) ? S_DIVX : S_DIVY;
				end
				S_DIVX, S_DIVY: begin
					if (rsp.ge) begin
						rem_q <= rsp.res[REM_W-1:0];
					end else begin
						rem_q <= REM_W'(div_a);
					end
					quo_q <= quo_nx;
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - CYC_W'(1);
					end else if (state_q == S_DIVX) begin
						px_q    <= sat_add(cx_q, quo_nx, dx_q[COORD_W]);
						state_q <= S_MY;
					end else begin
						py_q     <= sat_add(cy_q, quo_nx, dy_q[COORD_W]);
						pushed_q <= 1'b1;
						idx_q    <= idx_q + CNT_W'(1);
						state_q  <= S_READ;
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rd_idx      = idx_q[IDX_W-1:0];
	assign idle        = (state_q == S_IDLE);
	assign res_valid   = (state_q == S_DONE);
	assign res.x       = px_q;
	assign res.y       = py_q;
	assign res.touched = touched_q;
	assign res.pushed  = pushed_q;

endmodule

`default_nettype wire
